// ===== design/argbcv_pkg.sv =====
// ----------------------------------------------------------------------------
// argbcv_pkg
// Shared constants, codes and controller/datapath interface types for the
// argb convolution filter.
// ----------------------------------------------------------------------------
package argbcv_pkg;

   localparam int MAX_KERNEL_DEF = 5;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 4096;

   localparam int ROW_W      = 12;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int KSIZE_W    = 3;
   localparam int FUNC_W     = 2;
   localparam int CIDX_W     = 5;
   localparam int COEF_W     = 16;
   localparam int PIX_W      = 8;
   localparam int FRAC_BITS  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   localparam logic [COEF_W-1:0] COEF_ONE = 16'h1000;

   localparam logic [FUNC_W-1:0] FUNC_COEF  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 2'd3;

   typedef struct packed {
      logic latch;
      logic kern_wr;
      logic push;
      logic restart;
      logic tap_start;
      logic tap_issue;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              in_done;
      logic              emit_ok;
      logic              out_empty;
      logic              tap_last;
      logic              out_free;
   } stat_type;

endpackage

// ===== design/argb_convolution_clamp_edge.sv =====
// ----------------------------------------------------------------------------
// argb_convolution_clamp_edge
// 2D convolution of a raster-order ARGB8888 stream with up to a
// MAX_KERNEL x MAX_KERNEL Q4.12 kernel, border pixels replicated.
// ----------------------------------------------------------------------------
// One item is handled at a time: a coefficient load, a pixel push that gives
// no output and an ignored item are each decided and done alone. For an item
// that gives a filtered pixel, one multiply-accumulate per channel steps over
// the taps, one tap per cycle through the single read port of the line
// memory. The input takes a new item while a finished pixel waits in the
// output register. The line memory needs no clearing after reset; the kernel
// resets to the identity.
module argb_convolution_clamp_edge #(
   parameter int MAX_KERNEL = argbcv_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH  = argbcv_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [argbcv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [argbcv_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coef_index, coef_value, in_red, in_green, in_blue, in_alpha, zero pad
   input  logic [argbcv_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [argbcv_pkg::FUNC_W-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [argbcv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast
);

   import argbcv_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   argbcv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   argbcv_dp #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== design/argbcv_ram.sv =====
// ----------------------------------------------------------------------------
// argbcv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module argbcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/argbcv_ctrl.sv =====
// ----------------------------------------------------------------------------
// argbcv_ctrl
// Sequencer: takes one item, decides its action and steps the shared
// multiply-accumulate over the kernel taps.
// ----------------------------------------------------------------------------
module argbcv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  argbcv_pkg::stat_type stat,
   output argbcv_pkg::cmd_type  cmd
);

   import argbcv_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_TAP    = 3'd2;
   localparam logic [2:0] S_LAST   = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.latch = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            case (stat.func)
               FUNC_COEF: begin
                  cmd.kern_wr = 1'b1;
               end
               FUNC_PIXEL: begin
                  if (!stat.in_done) begin
                     if (stat.emit_ok) begin
                        cmd.tap_start = 1'b1;
                        state_in      = S_TAP;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
               end
               FUNC_FLUSH: begin
                  if (stat.in_done) begin
                     if (stat.out_empty) begin
                        cmd.restart = 1'b1;
                     end else begin
                        cmd.tap_start = 1'b1;
                        state_in      = S_TAP;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_TAP: begin
            cmd.tap_issue = 1'b1;
            if (stat.tap_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            // pixel is stored only after every tap has been read
            cmd.push = (stat.func == FUNC_PIXEL);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== design/argbcv_dp.sv =====
// ----------------------------------------------------------------------------
// argbcv_dp
// Datapath: configuration registers, position counters, line and kernel
// memories, tap address generation, four channel accumulators and the
// output register.
// ----------------------------------------------------------------------------
module argbcv_dp #(
   parameter int MAX_KERNEL = argbcv_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH  = argbcv_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [argbcv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [argbcv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [argbcv_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [argbcv_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [argbcv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   input  argbcv_pkg::cmd_type                   cmd,
   output argbcv_pkg::stat_type                  stat
);

   import argbcv_pkg::*;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int IDX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int K_W    = $clog2(MAX_KERNEL + 1);
   localparam int MOD_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int KD     = MAX_KERNEL * MAX_KERNEL;
   localparam int KA_W   = (KD > 1) ? $clog2(KD) : 1;
   localparam int LD     = MAX_KERNEL * MAX_WIDTH;
   localparam int LA_W   = $clog2(LD);
   localparam int YS_W   = ROW_W + 2;
   localparam int XS_W   = COL_W + 2;
   localparam int YM_W   = $clog2(2 * MAX_KERNEL) + 2;
   localparam int PROD_W = PIX_W + 1 + COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(KD) + 1;
   localparam int SH_W   = ACC_W - FRAC_BITS;

   // configuration
   logic [WIDTH_W-1:0]  cfg_w_ff;
   logic [HEIGHT_W-1:0] cfg_h_ff;
   logic [KSIZE_W-1:0]  cfg_kw_ff;
   logic [KSIZE_W-1:0]  cfg_kh_ff;

   // latched item
   logic [FUNC_W-1:0]        func_ff;
   logic [CIDX_W-1:0]        cidx_ff;
   logic [COEF_W-1:0]        cval_ff;
   logic [4*PIX_W-1:0]       pix_ff;

   // positions
   logic [COL_W-1:0] in_col_ff;
   logic [ROW_W-1:0] in_row_ff;
   logic [MOD_W-1:0] in_rmod_ff;
   logic [IDX_W-1:0] in_idx_ff;
   logic             in_done_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic [MOD_W-1:0] out_rmod_ff;
   logic [IDX_W-1:0] out_idx_ff;

   // taps
   logic [K_W-1:0]  tap_r_ff;
   logic [K_W-1:0]  tap_c_ff;
   logic [KA_W-1:0] tap_k_ff;
   logic            mac_en_ff;
   logic [KD-1:0]   kv_ff;
   logic            kv_rd_ff;
   logic            kz_rd_ff;
   logic            byp_ff;
   logic signed [ACC_W-1:0] acc_ff [4];

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic [W_W-1:0]      w_sat;
   logic [HEIGHT_W-1:0] h_sat;
   logic [K_W-1:0]      kw_sat;
   logic [K_W-1:0]      kh_sat;
   logic [K_W-1:0]      ar;
   logic [K_W-1:0]      ac;
   logic [IDX_W-1:0]    total;
   logic [IDX_W-1:0]    lag;
   logic                kern_ok;
   logic                frame_last;

   logic signed [YS_W-1:0] y_s;
   logic signed [YS_W-1:0] dy_s;
   logic signed [YM_W-1:0] ym_s;
   logic signed [XS_W-1:0] x_s;
   logic [MOD_W-1:0]       ymod;
   logic [LA_W-1:0]        line_raddr;
   logic [LA_W-1:0]        line_waddr;
   logic [4*PIX_W-1:0]     line_rdata;
   logic                   byp_hit;
   logic [4*PIX_W-1:0]     tap_pix;
   logic [COEF_W-1:0]      k_rdata;
   logic signed [COEF_W-1:0] coef;
   logic signed [PROD_W-1:0] prod [4];
   logic [PIX_W-1:0]       chan [4];
   logic signed [SH_W-1:0] shifted [4];

   // saturated sizes
   always_comb begin
      if (cfg_w_ff == '0) begin
         w_sat = W_W'(1);
      end else if (int'(cfg_w_ff) > MAX_WIDTH) begin
         w_sat = W_W'(MAX_WIDTH);
      end else begin
         w_sat = W_W'(cfg_w_ff);
      end
      if (cfg_h_ff == '0) begin
         h_sat = HEIGHT_W'(1);
      end else if (int'(cfg_h_ff) > MAX_HEIGHT) begin
         h_sat = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_sat = cfg_h_ff;
      end
      if (cfg_kw_ff == '0) begin
         kw_sat = K_W'(1);
      end else if (int'(cfg_kw_ff) > MAX_KERNEL) begin
         kw_sat = K_W'(MAX_KERNEL);
      end else begin
         kw_sat = K_W'(cfg_kw_ff);
      end
      if (cfg_kh_ff == '0) begin
         kh_sat = K_W'(1);
      end else if (int'(cfg_kh_ff) > MAX_KERNEL) begin
         kh_sat = K_W'(MAX_KERNEL);
      end else begin
         kh_sat = K_W'(cfg_kh_ff);
      end
   end

   assign ar      = kh_sat - K_W'(1) - (kh_sat >> 1);
   assign ac      = kw_sat - K_W'(1) - (kw_sat >> 1);
   assign total   = IDX_W'(w_sat) * IDX_W'(h_sat);
   assign lag     = IDX_W'(ar) * IDX_W'(w_sat) + IDX_W'(ac);
   assign kern_ok = int'(cidx_ff) < int'(kw_sat) * int'(kh_sat);
   assign frame_last = ({1'b0, out_idx_ff} + (IDX_W + 1)'(1)) >= {1'b0, total};

   assign stat.func      = func_ff;
   assign stat.in_done   = in_done_ff;
   assign stat.out_empty = out_idx_ff >= total;
   assign stat.emit_ok   = (out_idx_ff < total) &&
                           ({1'b0, in_idx_ff} >= ({1'b0, out_idx_ff} + {1'b0, lag}));
   assign stat.tap_last  = (tap_r_ff == kh_sat - K_W'(1)) && (tap_c_ff == kw_sat - K_W'(1));
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // tap address, clamped to the image border
   always_comb begin
      y_s = signed'(YS_W'(out_row_ff)) + signed'(YS_W'(tap_r_ff)) -
            signed'(YS_W'(kh_sat >> 1));
      if (y_s < 0) begin
         y_s = '0;
      end else if (y_s > signed'(YS_W'(h_sat - HEIGHT_W'(1)))) begin
         y_s = signed'(YS_W'(h_sat - HEIGHT_W'(1)));
      end
      dy_s = y_s - signed'(YS_W'(out_row_ff));
      ym_s = signed'(YM_W'(out_rmod_ff)) + signed'(YM_W'(dy_s));
      if (ym_s < 0) begin
         ym_s = ym_s + signed'(YM_W'(MAX_KERNEL));
      end else if (ym_s >= signed'(YM_W'(MAX_KERNEL))) begin
         ym_s = ym_s - signed'(YM_W'(MAX_KERNEL));
      end
      ymod = ym_s[MOD_W-1:0];
      x_s = signed'(XS_W'(out_col_ff)) + signed'(XS_W'(tap_c_ff)) -
            signed'(XS_W'(kw_sat >> 1));
      if (x_s < 0) begin
         x_s = '0;
      end else if (x_s > signed'(XS_W'(w_sat - W_W'(1)))) begin
         x_s = signed'(XS_W'(w_sat - W_W'(1)));
      end
      line_raddr = LA_W'(ymod) * LA_W'(MAX_WIDTH) + LA_W'(x_s[COL_W-1:0]);
   end

   // tap on the pixel being pushed takes it from the item register
   assign byp_hit = (func_ff == FUNC_PIXEL) &&
                    (y_s == signed'(YS_W'(in_row_ff))) &&
                    (x_s == signed'(XS_W'(in_col_ff)));

   assign line_waddr = LA_W'(in_rmod_ff) * LA_W'(MAX_WIDTH) + LA_W'(in_col_ff);

   argbcv_ram #(
      .WIDTH (4 * PIX_W),
      .DEPTH (LD)
   ) u_line_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (line_waddr),
      .wdata (pix_ff),
      .raddr (line_raddr),
      .rdata (line_rdata)
   );

   argbcv_ram #(
      .WIDTH (COEF_W),
      .DEPTH (KD)
   ) u_kern_ram (
      .clock (clock),
      .we    (cmd.kern_wr && kern_ok),
      .waddr (KA_W'(cidx_ff)),
      .wdata (cval_ff),
      .raddr (tap_k_ff),
      .rdata (k_rdata)
   );

   // unwritten kernel entries read as zero, but an unwritten first entry reads as one
   assign coef = kv_rd_ff ? signed'(k_rdata) : (kz_rd_ff ? signed'(COEF_ONE) : '0);

   assign tap_pix = byp_ff ? pix_ff : line_rdata;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         prod[ch]    = signed'({1'b0, tap_pix[PIX_W*ch +: PIX_W]}) * coef;
         shifted[ch] = SH_W'(acc_ff[ch] >>> FRAC_BITS);
         if (acc_ff[ch] < 0) begin
            chan[ch] = '0;
         end else if (shifted[ch] > signed'(SH_W'(255))) begin
            chan[ch] = 8'hFF;
         end else begin
            chan[ch] = shifted[ch][PIX_W-1:0];
         end
      end
   end

   // configuration and item capture
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= WIDTH_W'(640);
         cfg_h_ff  <= HEIGHT_W'(480);
         cfg_kw_ff <= KSIZE_W'(1);
         cfg_kh_ff <= KSIZE_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_w_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_h_ff  <= csr_wdata[HEIGHT_W-1:0];
            CSR_KERNEL_WIDTH:  cfg_kw_ff <= csr_wdata[KSIZE_W-1:0];
            CSR_KERNEL_HEIGHT: cfg_kh_ff <= csr_wdata[KSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= FUNC_COEF;
      end else if (cmd.latch) begin
         func_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cidx_ff <= req_tdata[4:0];
         cval_ff <= req_tdata[20:5];
         // stored as alpha, red, green, blue from the top byte down
         pix_ff  <= {req_tdata[52:45], req_tdata[28:21], req_tdata[36:29],
                     req_tdata[44:37]};
      end
   end

   // position counters
   always_ff @(posedge clock) begin
      if (reset || cmd.restart || (cmd.emit && frame_last)) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_rmod_ff  <= '0;
         in_idx_ff   <= '0;
         in_done_ff  <= 1'b0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_rmod_ff <= '0;
         out_idx_ff  <= '0;
      end else begin
         if (cmd.push) begin
            if (({1'b0, in_idx_ff} + (IDX_W + 1)'(1)) >= {1'b0, total}) begin
               in_done_ff <= 1'b1;
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               in_rmod_ff <= '0;
               in_idx_ff  <= '0;
            end else begin
               in_idx_ff <= in_idx_ff + IDX_W'(1);
               if (int'(in_col_ff) + 1 >= int'(w_sat)) begin
                  in_col_ff  <= '0;
                  in_row_ff  <= in_row_ff + ROW_W'(1);
                  in_rmod_ff <= (in_rmod_ff == MOD_W'(MAX_KERNEL - 1)) ? '0 :
                                in_rmod_ff + MOD_W'(1);
               end else begin
                  in_col_ff <= in_col_ff + COL_W'(1);
               end
            end
         end
         if (cmd.emit) begin
            out_idx_ff <= out_idx_ff + IDX_W'(1);
            if (int'(out_col_ff) + 1 >= int'(w_sat)) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + ROW_W'(1);
               out_rmod_ff <= (out_rmod_ff == MOD_W'(MAX_KERNEL - 1)) ? '0 :
                              out_rmod_ff + MOD_W'(1);
            end else begin
               out_col_ff <= out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // tap stepping and kernel valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_r_ff  <= '0;
         tap_c_ff  <= '0;
         tap_k_ff  <= '0;
         mac_en_ff <= 1'b0;
         kv_ff     <= '0;
      end else begin
         mac_en_ff <= cmd.tap_issue;
         if (cmd.kern_wr && kern_ok) begin
            kv_ff[KA_W'(cidx_ff)] <= 1'b1;
         end
         if (cmd.tap_start) begin
            tap_r_ff <= '0;
            tap_c_ff <= '0;
            tap_k_ff <= '0;
         end else if (cmd.tap_issue) begin
            tap_k_ff <= tap_k_ff + KA_W'(1);
            if (tap_c_ff == kw_sat - K_W'(1)) begin
               tap_c_ff <= '0;
               tap_r_ff <= tap_r_ff + K_W'(1);
            end else begin
               tap_c_ff <= tap_c_ff + K_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      kv_rd_ff <= kv_ff[tap_k_ff];
      kz_rd_ff <= (tap_k_ff == '0);
      byp_ff   <= byp_hit;
      for (int ch = 0; ch < 4; ch++) begin
         if (cmd.tap_start) begin
            acc_ff[ch] <= '0;
         end else if (mac_en_ff) begin
            acc_ff[ch] <= acc_ff[ch] + ACC_W'(prod[ch]);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {chan[3], chan[0], chan[1], chan[2]};
         rsp_last_ff <= frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives argb_convolution_clamp_edge with whole frames of random pixels over
// many image and kernel sizes, coefficient loads, flushes and ignored items.
// A frame-level model of the filter predicts every output pixel, which is
// compared field by field against the result stream.
// ----------------------------------------------------------------------------
module testbench;
   import argbcv_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } argb_out_type;

   class conv_scoreboard;
      logic [WIDTH_W-1:0]  img_w_reg;
      logic [HEIGHT_W-1:0] img_h_reg;
      logic [KSIZE_W-1:0]  kern_w_reg;
      logic [KSIZE_W-1:0]  kern_h_reg;
      logic signed [COEF_W-1:0] coefs[25];
      logic [31:0] rows[5*1024];
      int in_col, in_row, out_col, out_row;
      bit in_done;
      argb_out_type pending[$];
      int errors, pixels_in, outputs, frames;

      function new();
         img_w_reg = 640;
         img_h_reg = 480;
         kern_w_reg = 1;
         kern_h_reg = 1;
         foreach (coefs[i]) coefs[i] = 0;
         coefs[0] = COEF_ONE;
         foreach (rows[i]) rows[i] = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         in_done = 0;
      endfunction

      function int sat(int v, int lo, int hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function int img_w(); return sat(img_w_reg, 1, 1024); endfunction
      function int img_h(); return sat(img_h_reg, 1, 4096); endfunction
      function int kern_w(); return sat(kern_w_reg, 1, 5); endfunction
      function int kern_h(); return sat(kern_h_reg, 1, 5); endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_IMAGE_WIDTH: img_w_reg = val[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: img_h_reg = val[HEIGHT_W-1:0];
            CSR_KERNEL_WIDTH: kern_w_reg = val[KSIZE_W-1:0];
            default: kern_h_reg = val[KSIZE_W-1:0];
         endcase
      endfunction

      function logic [7:0] clip(int acc);
         if (acc < 0) return 8'd0;
         acc = acc >>> FRAC_BITS;
         return acc > 255 ? 8'd255 : acc[7:0];
      endfunction

      function void filter_pixel(bit bypass, int bx, int by, logic [31:0] bpix);
         int acc[4];
         int x, y, kw, kh, k;
         logic [31:0] p;
         argb_out_type res;
         kw = kern_w();
         kh = kern_h();
         acc = '{0, 0, 0, 0};
         for (int r = 0; r < kh; r++) begin
            y = sat(out_row - kh / 2 + r, 0, img_h() - 1);
            for (int c = 0; c < kw; c++) begin
               x = sat(out_col - kw / 2 + c, 0, img_w() - 1);
               k = coefs[r * kw + c];
               if (bypass && y == by && x == bx) p = bpix;
               else p = rows[(y % 5) * 1024 + (x % 1024)];
               for (int ch = 0; ch < 4; ch++) acc[ch] += int'(p[8*ch +: 8]) * k;
            end
         end
         res.blue = clip(acc[0]);
         res.green = clip(acc[1]);
         res.red = clip(acc[2]);
         res.alpha = clip(acc[3]);
         res.last = (out_row * img_w() + out_col + 1) >= img_w() * img_h();
         pending.push_back(res);
         if (res.last) begin
            restart_frame();
            frames++;
         end else if (out_col + 1 >= img_w()) begin
            out_col = 0;
            out_row++;
         end else out_col++;
      endfunction

      function void note(logic [FUNC_W-1:0] func, logic [REQ_DATA_W-1:0] d);
         int total, oidx, n, lag;
         bit emit;
         logic [31:0] pix;
         total = img_w() * img_h();
         oidx = out_row * img_w() + out_col;
         case (func)
            FUNC_COEF: begin
               if (d[4:0] < kern_w() * kern_h()) coefs[d[4:0]] = d[20:5];
            end
            FUNC_PIXEL: begin
               if (!in_done) begin
                  pixels_in++;
                  n = in_row * img_w() + in_col;
                  lag = (kern_h() - 1 - kern_h() / 2) * img_w() + (kern_w() - 1 - kern_w() / 2);
                  pix = {d[52:45], d[28:21], d[36:29], d[44:37]};
                  emit = (oidx < total) && (n >= oidx + lag);
                  if (emit) filter_pixel(1, in_col, in_row, pix);
                  else rows[(in_row % 5) * 1024 + (in_col % 1024)] = pix;
                  if (emit) rows[(in_row % 5) * 1024 + (in_col % 1024)] = pix;
                  if (emit && pending[$].last) begin
                     // frame already restarted by the final output
                  end else if (n + 1 >= total) begin
                     in_done = 1; in_col = 0; in_row = 0;
                  end else if (in_col + 1 >= img_w()) begin
                     in_col = 0; in_row++;
                  end else in_col++;
               end
            end
            FUNC_FLUSH: begin
               if (in_done) begin
                  if (oidx >= total) restart_frame();
                  else filter_pixel(0, 0, 0, 0);
               end
            end
            default: ;
         endcase
      endfunction

      function void check(logic [RSP_DATA_W-1:0] d, logic last);
         argb_out_type e;
         if (pending.size() == 0) begin
            $error("unexpected output item %h last %b", d, last);
            errors++;
            return;
         end
         e = pending.pop_front();
         outputs++;
         if (d[7:0] !== e.red) begin
            $error("out_red expected %0d actual %0d", e.red, d[7:0]); errors++;
         end
         if (d[15:8] !== e.green) begin
            $error("out_green expected %0d actual %0d", e.green, d[15:8]); errors++;
         end
         if (d[23:16] !== e.blue) begin
            $error("out_blue expected %0d actual %0d", e.blue, d[23:16]); errors++;
         end
         if (d[31:24] !== e.alpha) begin
            $error("out_alpha expected %0d actual %0d", e.alpha, d[31:24]); errors++;
         end
         if (last !== e.last) begin
            $error("frame_last expected %0d actual %0d", e.last, last); errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   conv_scoreboard sb = new();
   bit quiet;
   bit hold_req;
   int hold_left;
   int sent;

   argb_convolution_clamp_edge dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            rsp_tready = 0;
            hold_left--;
         end else rsp_tready = quiet || ($urandom_range(0, 99) >= 36);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tlast);

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(val);
      @(negedge clock);
      csr_we = 0;
      sb.write_reg(idx, CSR_DATA_W'(val));
   endtask

   task automatic send_item(logic [FUNC_W-1:0] func, logic [REQ_DATA_W-1:0] d);
      if (!quiet && $urandom_range(0, 99) < 36) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = func;
      req_tdata = d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(func, d);
      sent++;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   function automatic logic [REQ_DATA_W-1:0] rand_data();
      return REQ_DATA_W'({$urandom, $urandom});
   endfunction

   function automatic logic [REQ_DATA_W-1:0] coef_item(int idx, logic [15:0] val);
      logic [REQ_DATA_W-1:0] d;
      d = rand_data();
      d[4:0] = 5'(idx);
      d[20:5] = val;
      d[55:53] = '0;
      return d;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pixel_item(logic [31:0] argb);
      logic [REQ_DATA_W-1:0] d;
      d = rand_data();
      d[28:21] = argb[23:16];
      d[36:29] = argb[15:8];
      d[44:37] = argb[7:0];
      d[52:45] = argb[31:24];
      d[55:53] = '0;
      return d;
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 4))
         0, 1: return 16'($urandom_range(0, 2048));
         2: return 16'(-int'($urandom_range(0, 1024)));
         3: return 16'($urandom);
         default: return COEF_ONE;
      endcase
   endfunction

   task automatic wait_idle();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic run_frame(int w, int h, int kw, int kh, bit noisy);
      int kcount;
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_KERNEL_WIDTH, kw);
      csr_write(CSR_KERNEL_HEIGHT, kh);
      kcount = sb.kern_w() * sb.kern_h();
      for (int i = 0; i < kcount; i++) send_item(FUNC_COEF, coef_item(i, rand_coef()));
      for (int n = 0; n < sb.img_w() * sb.img_h(); n++) begin
         if (noisy && $urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 3))
               0: send_item(FUNC_UNUSED, rand_data());
               1: send_item(FUNC_FLUSH, rand_data());
               2: send_item(FUNC_COEF, coef_item($urandom_range(kcount, 31),
                                                 16'($urandom)));
               default: send_item(FUNC_COEF, coef_item($urandom_range(0, kcount - 1),
                                                       rand_coef()));
            endcase
         end
         send_item(FUNC_PIXEL, pixel_item($urandom));
      end
      if (noisy && sb.in_done && $urandom_range(0, 99) < 40)
         send_item(FUNC_PIXEL, pixel_item($urandom));
      while (sb.in_done) send_item(FUNC_FLUSH, rand_data());
      if (noisy && $urandom_range(0, 99) < 20) send_item(FUNC_FLUSH, rand_data());
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = 0;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = FUNC_COEF;
      quiet = 1;
      hold_req = 0;
      sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // identity kernel from reset, extreme pixel values, ignored items
      csr_write(CSR_IMAGE_HEIGHT, 8191);
      csr_write(CSR_IMAGE_HEIGHT, 4096);
      csr_write(CSR_IMAGE_WIDTH, 3);
      csr_write(CSR_IMAGE_HEIGHT, 2);
      send_item(FUNC_UNUSED, '1);
      send_item(FUNC_FLUSH, '0);
      send_item(FUNC_COEF, coef_item(24, 16'h7fff));
      send_item(FUNC_PIXEL, pixel_item(32'h0000_0000));
      send_item(FUNC_PIXEL, pixel_item(32'hffff_ffff));
      send_item(FUNC_PIXEL, pixel_item(32'hff00_ff00));
      send_item(FUNC_PIXEL, pixel_item(32'h00ff_00ff));
      send_item(FUNC_PIXEL, pixel_item(32'h1234_5678));
      send_item(FUNC_PIXEL, pixel_item(32'hffff_ffff));
      // saturated sizes, extreme coefficients on a single-pixel frame
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 0);
      csr_write(CSR_IMAGE_HEIGHT, 0);
      csr_write(CSR_KERNEL_WIDTH, 2);
      csr_write(CSR_KERNEL_HEIGHT, 2);
      send_item(FUNC_COEF, coef_item(0, 16'h7fff));
      send_item(FUNC_COEF, coef_item(1, 16'h8000));
      send_item(FUNC_COEF, coef_item(2, 16'h8000));
      send_item(FUNC_COEF, coef_item(3, 16'h7fff));
      send_item(FUNC_PIXEL, pixel_item(32'hff80_ff01));
      run_frame(4, 3, 3, 3, 0);

      // stall the result side, which holds back the pixel input
      run_frame(6, 4, 1, 1, 0);
      wait_idle();
      hold_req = 1;
      run_frame(8, 5, 1, 1, 0);
      quiet = 0;

      // largest kernel, saturated kernel sizes
      run_frame(40, 6, 7, 6, 1);
      while (sent < 1050) begin
         if ($urandom_range(0, 5) == 0) quiet = 1;
         run_frame($urandom_range(0, 12), $urandom_range(0, 8),
                   $urandom_range(0, 7), $urandom_range(0, 7), 1);
         quiet = 0;
      end
      req_tvalid = 0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      $display("covered %0d items, %0d pixels pushed, %0d filtered pixels over %0d frames",
               sent, sb.pixels_in, sb.outputs, sb.frames);
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/argbcv_pkg.sv
design/argbcv_ram.sv
design/argbcv_ctrl.sv
design/argbcv_dp.sv
design/argb_convolution_clamp_edge.sv
sim/testbench.sv
